// ===== hdl/spt_pkg.sv =====
// shared types for the stride prediction table
// confidence codes, controller states and the controller/datapath command and status bundles
package spt_pkg;

	localparam int unsigned DATA_W = 64;

	typedef enum logic [1:0] {
		CONF_INIT   = 2'd0,
		CONF_STEADY = 2'd1,
		CONF_TRANS  = 2'd2,
		CONF_NOPRED = 2'd3
	} conf_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;  // capture item, start set/tag split
		logic mem_rd;  // read the entry
		logic update;  // write back entry, load result register
	} spt_cmd_t;

	typedef struct packed {
		logic div_done;
	} spt_status_t;

endpackage

// ===== hdl/stride_prediction_table_unit.sv =====
// stride prediction table, one load in, one prefetch decision out
// sequence: accept, pc / set-count split (a registered bit slice with a power of two set count,
// else a long division by 16-bit digits), ram read and write-back, which waits for a free
// result slot; one item in flight at a time, the next is taken only after the write-back
// reset: asynchronous, all entries invalid, seen flags clear, tracked pc and stride zero
// depends on spt_pkg, spt_ctrl, spt_datapath
module stride_prediction_table_unit #(
	parameter int unsigned NUM_SETS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] load_pc, [127:64] load_address
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata   // [0] wait_flag, [1] clear_table_flag,
	                                    // [2] can_prefetch, [3] stride_match,
	                                    // [67:4] tracked_stride, [71:68] zero
);
	import spt_pkg::*;

	spt_cmd_t          cmd;
	spt_status_t       status;
	logic              wait_flag;
	logic              clear_table_flag;
	logic              can_prefetch;
	logic              stride_match;
	logic [DATA_W-1:0] tracked_stride;

	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	spt_datapath #(
		.NUM_SETS(NUM_SETS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_pc           (s_axis_tdata[63:0]),
		.in_address      (s_axis_tdata[127:64]),
		.wait_flag       (wait_flag),
		.clear_table_flag(clear_table_flag),
		.can_prefetch    (can_prefetch),
		.stride_match    (stride_match),
		.tracked_stride  (tracked_stride)
	);

	assign m_axis_tdata = {4'b0000, tracked_stride, stride_match, can_prefetch,
		clear_table_flag, wait_flag};

endmodule

// ===== hdl/spt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module spt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/spt_divider.sv =====
// splits a load pc into set index (pc mod NUM_SETS) and tag (pc / NUM_SETS)
// power of two set counts take a registered bit slice, others a radix 2^16 long division by
// reciprocal multiplication; depends on spt_pkg
module spt_divider #(
	parameter int unsigned NUM_SETS = 256
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [spt_pkg::DATA_W-1:0]                   pc,
	output logic                                         done,
	output logic [spt_pkg::DATA_W-($clog2(NUM_SETS+1)-1)-1:0] tag,
	output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0]  idx
);
	import spt_pkg::*;

	localparam int unsigned LOG_FLOOR = $clog2(NUM_SETS + 1) - 1;
	localparam int unsigned TAG_W     = DATA_W - LOG_FLOOR;
	localparam int unsigned IDX_W     = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
	localparam bit          IS_POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;

	logic done_q;

	assign done = done_q;

	generate
		if (IS_POW2) begin : g_pow2
			logic [TAG_W-1:0] tag_q;
			logic [IDX_W-1:0] idx_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					tag_q <= pc[DATA_W-1:LOG_FLOOR];
					idx_q <= (NUM_SETS > 1) ? pc[IDX_W-1:0] : '0;
				end
			end

			assign tag = tag_q;
			assign idx = idx_q;
		end else begin : g_serial
			localparam int unsigned DIG_W   = 16;
			localparam int unsigned N_DIG   = DATA_W / DIG_W;
			localparam int unsigned CNT_W   = $clog2(N_DIG);
			localparam int unsigned NUM_W   = 2 * DIG_W;
			localparam int unsigned RECIP_W = NUM_W + 1;
			localparam int unsigned PROD_W  = NUM_W + RECIP_W;
			localparam int unsigned SHIFT   = NUM_W + IDX_W;
			// floor(2^SHIFT / NUM_SETS) + 1 is exact for every 32-bit numerator
			localparam logic [RECIP_W-1:0] RECIP =
				RECIP_W'(((64'd1 << SHIFT) / 64'(NUM_SETS)) + 64'd1);
			localparam logic [DIG_W-1:0] DIVISOR  = DIG_W'(NUM_SETS);
			localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(N_DIG - 1);

			logic              busy_q;
			logic              phase_q;
			logic [CNT_W-1:0]  cnt_q;
			logic [DATA_W-1:0] dividend_q;
			logic [DATA_W-1:0] quot_q;
			logic [IDX_W-1:0]  rem_q;
			logic [DIG_W-1:0]  qdig_q;
			logic [NUM_W-1:0]  num;
			logic [PROD_W-1:0] prod;
			logic [NUM_W-1:0]  back;

			// partial remainder followed by the next 16-bit digit, msb digit first
			always_comb begin
				num  = {DIG_W'(rem_q), dividend_q[DATA_W-1 -: DIG_W]};
				prod = PROD_W'(num) * PROD_W'(RECIP);
				back = num - NUM_W'(qdig_q) * NUM_W'(DIVISOR);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q  <= 1'b0;
					phase_q <= 1'b0;
					cnt_q   <= '0;
					done_q  <= 1'b0;
				end else begin
					done_q <= busy_q && phase_q && (cnt_q == LAST_DIG);
					if (start) begin
						busy_q  <= 1'b1;
						phase_q <= 1'b0;
						cnt_q   <= '0;
					end else if (busy_q) begin
						phase_q <= !phase_q;
						if (phase_q) begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == LAST_DIG) begin
								busy_q <= 1'b0;
							end
						end
					end
				end
			end

			// the first phase of a digit takes its quotient digit, the second the remainder
			always_ff @(posedge clk) begin
				if (start) begin
					dividend_q <= pc;
					quot_q     <= '0;
					rem_q      <= '0;
				end else if (busy_q) begin
					if (!phase_q) begin
						qdig_q <= prod[SHIFT +: DIG_W];
					end else begin
						dividend_q <= {dividend_q[DATA_W-DIG_W-1:0], {DIG_W{1'b0}}};
						quot_q     <= {quot_q[DATA_W-DIG_W-1:0], qdig_q};
						rem_q      <= IDX_W'(back);
					end
				end
			end

			assign tag = quot_q[TAG_W-1:0];
			assign idx = rem_q;
		end
	endgenerate

endmodule

// ===== hdl/spt_datapath.sv =====
// datapath: item registers, entry ram, valid and seen flags, confidence update,
// tracked pc/stride and the result register; depends on spt_pkg, spt_divider, spt_ram
module spt_datapath #(
	parameter int unsigned NUM_SETS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spt_pkg::spt_cmd_t           cmd,
	output spt_pkg::spt_status_t        status,
	input  logic [spt_pkg::DATA_W-1:0]  in_pc,
	input  logic [spt_pkg::DATA_W-1:0]  in_address,
	output logic                        wait_flag,
	output logic                        clear_table_flag,
	output logic                        can_prefetch,
	output logic                        stride_match,
	output logic [spt_pkg::DATA_W-1:0]  tracked_stride
);
	import spt_pkg::*;

	localparam int unsigned LOG_FLOOR = $clog2(NUM_SETS + 1) - 1;
	localparam int unsigned TAG_W     = DATA_W - LOG_FLOOR;
	localparam int unsigned IDX_W     = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
	localparam int unsigned ENTRY_W   = TAG_W + DATA_W + DATA_W + 2;

	logic [DATA_W-1:0]  pc_q;
	logic [DATA_W-1:0]  addr_q;
	logic [TAG_W-1:0]   tag;
	logic [IDX_W-1:0]   idx;
	logic               div_done;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;
	logic [NUM_SETS-1:0] valid_q;
	logic [NUM_SETS-1:0] seen_q;
	logic [DATA_W-1:0]  tracked_pc_q;
	logic [DATA_W-1:0]  tracked_stride_q;

	logic [TAG_W-1:0]   e_tag;
	logic [DATA_W-1:0]  e_last;
	logic [DATA_W-1:0]  e_stride;
	conf_t              e_conf;
	logic               hit;
	logic [DATA_W-1:0]  new_stride_raw;
	logic               match;
	logic               grant;
	conf_t              next_conf;
	conf_t              wr_conf;
	logic [DATA_W-1:0]  wr_stride;
	logic               seen_cur;
	logic               clear_all;
	logic               pc_is_tracked;
	logic               wait_n;

	logic               wait_q;
	logic               clr_q;
	logic               grant_q;
	logic               match_q;

	spt_divider #(
		.NUM_SETS(NUM_SETS)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.accept),
		.pc    (in_pc),
		.done  (div_done),
		.tag   (tag),
		.idx   (idx)
	);

	assign status.div_done = div_done;

	spt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SETS)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (cmd.update),
		.wr_addr(idx),
		.wr_data(wr_data),
		.rd_en  (cmd.mem_rd),
		.rd_addr(idx),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pc_q   <= in_pc;
			addr_q <= in_address;
		end
	end

	always_comb begin
		{e_tag, e_last, e_stride} = rd_data[ENTRY_W-1:2];
		e_conf         = conf_t'(rd_data[1:0]);
		hit            = valid_q[idx] && (e_tag == tag);
		new_stride_raw = addr_q - e_last;
		match          = hit && (new_stride_raw == e_stride) && (new_stride_raw != '0);
		case (e_conf)
			CONF_INIT: begin
				next_conf = match ? CONF_STEADY : CONF_TRANS;
				grant     = match;
			end
			CONF_STEADY: begin
				next_conf = match ? CONF_STEADY : CONF_INIT;
				grant     = 1'b1;
			end
			CONF_TRANS: begin
				next_conf = match ? CONF_STEADY : CONF_NOPRED;
				grant     = match;
			end
			default: begin
				next_conf = match ? CONF_TRANS : CONF_NOPRED;
				grant     = 1'b0;
			end
		endcase
		grant     = grant && hit;
		wr_conf   = hit ? next_conf : CONF_INIT;
		wr_stride = !hit ? '0 : (match ? e_stride : new_stride_raw);
		wr_data   = {tag, addr_q, wr_stride, wr_conf};
		seen_cur  = hit && seen_q[idx];
		clear_all = grant && seen_cur;
		// a second granted sighting of the same pc that is already tracked
		wait_n    = clear_all && (tracked_pc_q == pc_q);
		pc_is_tracked = clear_all || (tracked_pc_q == pc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q          <= '0;
			seen_q           <= '0;
			tracked_pc_q     <= '0;
			tracked_stride_q <= '0;
		end else if (cmd.update) begin
			valid_q[idx] <= 1'b1;
			if (clear_all) begin
				seen_q       <= '0;
				tracked_pc_q <= pc_q;
			end else if (grant) begin
				seen_q[idx] <= 1'b1;
			end else if (!hit) begin
				seen_q[idx] <= 1'b0;
			end
			if (pc_is_tracked) begin
				tracked_stride_q <= wr_stride;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			wait_q  <= wait_n;
			clr_q   <= clear_all;
			grant_q <= grant;
			match_q <= match;
		end
	end

	assign wait_flag        = wait_q;
	assign clear_table_flag = clr_q;
	assign can_prefetch     = grant_q;
	assign stride_match     = match_q;
	assign tracked_stride   = tracked_stride_q;

	a_clear_empties_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && clear_all) |=> (seen_q == '0))
		else $error("seen flags not cleared after a clear request");

	a_update_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> valid_q[$past(idx)])
		else $error("entry not marked valid after update");

	a_wait_needs_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.update) |-> (!wait_q || (clr_q && grant_q)))
		else $error("wait raised without a clear and a grant");

endmodule

// ===== hdl/spt_ctrl.sv =====
// controller: sequences accept, set/tag split, entry read and write-back,
// owns the result valid flag; depends on spt_pkg
module spt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spt_pkg::spt_cmd_t    cmd,
	input  spt_pkg::spt_status_t status
);
	import spt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.div_done) begin
					cmd.mem_rd = 1'b1;
					state_n    = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// result slot free or draining this cycle
				if (!out_valid_q || out_ready) begin
					cmd.update = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && out_valid_q && !out_ready)
		|=> (state_q == ST_UPDATE && out_valid_q))
		else $error("write-back went ahead into a full result slot");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("second item accepted while one is in flight");

	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("result not presented after write-back");

endmodule

// ===== verif/stride_prediction_table_unit_tb.sv =====
// self-checking testbench for stride_prediction_table_unit
// holds its own table model, drives loads on the input stream and checks every decision
// depends on spt_pkg and the stride_prediction_table_unit rtl
module stride_prediction_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spt_pkg::*;

	localparam int unsigned NUM_SETS = 256;
	localparam int RANDOM_LOADS = 2000;
	localparam int POOL = 12;
	localparam int DRAIN_CYCLES = 70;
	localparam int WATCHDOG_LIMIT = 5000;

	// field order matches m_axis_tdata, lowest bit last
	typedef struct packed {
		logic [3:0]  spare;
		logic [63:0] tracked_stride;
		logic        stride_match;
		logic        can_prefetch;
		logic        clear_table_flag;
		logic        wait_flag;
	} decision_t;

	typedef struct {
		logic [63:0] pc;
		logic [63:0] addr;
		bit          typed;
		decision_t   want;
	} load_row_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;

	// model of the table
	logic [NUM_SETS-1:0] tbl_valid = '0;
	logic [NUM_SETS-1:0] tbl_seen = '0;
	logic [63:0]         tbl_tag [NUM_SETS];
	logic [63:0]         tbl_last [NUM_SETS];
	logic [63:0]         tbl_stride [NUM_SETS];
	conf_t               tbl_conf [NUM_SETS];
	logic [63:0]         trk_pc = '0;
	logic [63:0]         trk_stride = '0;

	load_row_t  directed_loads[$];
	load_row_t  loads_in_flight[$];
	decision_t  pending_decisions[$];
	int         mismatches = 0;
	int         results_seen = 0;
	int         quiet_cycles = 0;
	bit         steady_run = 1'b0;

	stride_prediction_table_unit #(
		.NUM_SETS(NUM_SETS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic decision_t predict_load(input logic [63:0] pc, input logic [63:0] addr);
		decision_t   d;
		int unsigned set_idx;
		logic [63:0] tag;
		logic [63:0] step;
		logic        match;
		d = '0;
		match = 1'b0;
		set_idx = 32'(pc % NUM_SETS);
		tag = pc / NUM_SETS;
		if (tbl_valid[set_idx] && tbl_tag[set_idx] == tag) begin
			step = addr - tbl_last[set_idx];
			match = (step == tbl_stride[set_idx]) && (step != 0);
			case (tbl_conf[set_idx])
				CONF_INIT: begin
					tbl_conf[set_idx] = match ? CONF_STEADY : CONF_TRANS;
					d.can_prefetch = match;
				end
				CONF_STEADY: begin
					tbl_conf[set_idx] = match ? CONF_STEADY : CONF_INIT;
					d.can_prefetch = 1'b1;
				end
				CONF_TRANS: begin
					tbl_conf[set_idx] = match ? CONF_STEADY : CONF_NOPRED;
					d.can_prefetch = match;
				end
				default: begin
					tbl_conf[set_idx] = match ? CONF_TRANS : CONF_NOPRED;
					d.can_prefetch = 1'b0;
				end
			endcase
			// a broken stride is relearned straight away
			if (!match)
				tbl_stride[set_idx] = step;
		end else begin
			tbl_valid[set_idx] = 1'b1;
			tbl_tag[set_idx] = tag;
			tbl_stride[set_idx] = '0;
			tbl_conf[set_idx] = CONF_INIT;
			tbl_seen[set_idx] = 1'b0;
		end
		tbl_last[set_idx] = addr;
		d.stride_match = match;

		if (d.can_prefetch && tbl_seen[set_idx]) begin
			tbl_seen = '0;
			d.clear_table_flag = 1'b1;
			if (trk_pc != pc)
				trk_pc = pc;
			else
				d.wait_flag = 1'b1;
		end else if (d.can_prefetch) begin
			tbl_seen[set_idx] = 1'b1;
		end

		if (trk_pc == pc)
			trk_stride = tbl_stride[set_idx];
		d.tracked_stride = trk_stride;
		return d;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s of result %0d: got %h, expected %h",
			field, results_seen, got, want);
		mismatches++;
	endtask

	// flags are {stride_match, can_prefetch, clear_table_flag, wait_flag}
	task automatic add_row(input logic [63:0] pc, input logic [63:0] addr, input bit typed,
			input logic [3:0] flags, input logic [63:0] stride);
		load_row_t row;
		row.pc = pc;
		row.addr = addr;
		row.typed = typed;
		row.want = {4'd0, stride, flags};
		directed_loads.push_back(row);
	endtask

	task automatic drive_load(input load_row_t row);
		int gap;
		gap = 0;
		if (!steady_run)
			while ($urandom_range(99) < 31)
				gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		loads_in_flight.push_back(row);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row.addr, row.pc};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady_run || ($urandom_range(99) >= 31);
	end

	// accept side feeds the model, result side checks against it
	always @(posedge clk) begin : scoreboard
		load_row_t row;
		decision_t pred;
		decision_t got;
		decision_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				row = loads_in_flight.pop_front();
				pred = predict_load(row.pc, row.addr);
				pending_decisions.push_back(row.typed ? row.want : pred);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_decisions.size() == 0) begin
					report_mismatch("result with nothing expected", got[63:0], '0);
				end else begin
					want = pending_decisions.pop_front();
					if (got.wait_flag !== want.wait_flag)
						report_mismatch("wait_flag", 64'(got.wait_flag),
							64'(want.wait_flag));
					if (got.clear_table_flag !== want.clear_table_flag)
						report_mismatch("clear_table_flag", 64'(got.clear_table_flag),
							64'(want.clear_table_flag));
					if (got.can_prefetch !== want.can_prefetch)
						report_mismatch("can_prefetch", 64'(got.can_prefetch),
							64'(want.can_prefetch));
					if (got.stride_match !== want.stride_match)
						report_mismatch("stride_match", 64'(got.stride_match),
							64'(want.stride_match));
					if (got.tracked_stride !== want.tracked_stride)
						report_mismatch("tracked_stride", got.tracked_stride,
							want.tracked_stride);
				end
				results_seen++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("stride_prediction_table_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [63:0] pool_pc [POOL];
		logic [63:0] pool_addr [POOL];
		logic [63:0] pool_stride [POOL];
		load_row_t   row;
		logic [63:0] step;
		int          k;
		int          r;

		// pc 0 is the tracked pc out of reset
		add_row(64'h0, 64'h1000, 1'b1, 4'b0000, 64'h0);
		add_row(64'h0, 64'h1010, 1'b0, 4'b0000, 64'h0);
		add_row(64'h0, 64'h1020, 1'b0, 4'b0000, 64'h0);
		add_row(64'h0, 64'h1030, 1'b0, 4'b0000, 64'h0);
		// top set, top tag, walking down by one from the top address
		add_row('1, 64'h0, 1'b1, 4'b0000, 64'h10);
		add_row('1, '1, 1'b0, 4'b0000, 64'h0);
		add_row('1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 4'b0000, 64'h0);
		add_row('1, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1, 4'b1110, 64'hFFFF_FFFF_FFFF_FFFF);
		add_row('1, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 4'b0000, 64'h0);
		add_row('1, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, 4'b0000, 64'h0);
		// zero stride never matches, then down to no-prediction and back up
		add_row(64'h5, 64'h0, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h0, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h0, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h8, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h10, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h18, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h100, 1'b0, 4'b0000, 64'h0);
		// same set, other tag: entry is evicted both ways
		add_row(64'h105, 64'h200, 1'b0, 4'b0000, 64'h0);
		add_row(64'h5, 64'h108, 1'b0, 4'b0000, 64'h0);
		add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 4'b0000, 64'h0);
		add_row(64'h0, 64'h1040, 1'b0, 4'b0000, 64'h0);
		add_row(64'h8000_0000_0000_0000, 64'h0, 1'b0, 4'b0000, 64'h0);
		add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 4'b0000, 64'h0);
		add_row(64'h8000_0000_0000_0000, 64'h0, 1'b0, 4'b0000, 64'h0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_loads[i])
			drive_load(directed_loads[i]);

		// a small pool of loads, half of them aliasing the others' sets
		for (int i = 0; i < POOL; i++) begin
			pool_pc[i] = {$urandom, $urandom};
			if (i >= POOL / 2)
				pool_pc[i][7:0] = pool_pc[i - POOL / 2][7:0];
			pool_addr[i] = {$urandom, $urandom};
			pool_stride[i] = 64'($urandom_range(1, 32)) * 8;
		end

		for (int n = 0; n < RANDOM_LOADS; n++) begin
			steady_run = (n >= 900) && (n < 1200);
			k = $urandom_range(POOL - 1);
			r = $urandom_range(99);
			if (r < 4) begin
				pool_pc[k] = {$urandom, $urandom};
				pool_addr[k] = {$urandom, $urandom};
			end else if (r < 14) begin
				step = (r < 9) ? 64'($urandom_range(0, 32)) * 8 : {$urandom, $urandom};
				pool_stride[k] = $urandom_range(1) ? -step : step;
				pool_addr[k] = pool_addr[k] + pool_stride[k];
			end else if (r < 22) begin
				pool_addr[k] = {$urandom, $urandom};
			end else begin
				pool_addr[k] = pool_addr[k] + pool_stride[k];
			end
			row.pc = pool_pc[k];
			row.addr = pool_addr[k];
			row.typed = 1'b0;
			row.want = '0;
			drive_load(row);
		end
		steady_run = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_decisions.size() == 0)
			$display("stride_prediction_table_unit_tb passed");
		else
			$display("stride_prediction_table_unit_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/spt_pkg.sv
hdl/spt_ram.sv
hdl/spt_divider.sv
hdl/spt_datapath.sv
hdl/spt_ctrl.sv
hdl/stride_prediction_table_unit.sv
verif/stride_prediction_table_unit_tb.sv
